@@ sv/ams_pkg.sv @@
// Package: shared types, opcodes and status codes for the accumulator machine.
package ams_pkg;
    localparam int MEM_WORDS_DEF = 256;

    localparam logic [31:0] OP_ADD    = 32'd1;
    localparam logic [31:0] OP_SUB    = 32'd2;
    localparam logic [31:0] OP_MUL    = 32'd3;
    localparam logic [31:0] OP_DIV    = 32'd4;
    localparam logic [31:0] OP_JMP    = 32'd5;
    localparam logic [31:0] OP_JMPN   = 32'd6;
    localparam logic [31:0] OP_JMPP   = 32'd7;
    localparam logic [31:0] OP_JMPZ   = 32'd8;
    localparam logic [31:0] OP_COPY   = 32'd9;
    localparam logic [31:0] OP_LOAD   = 32'd10;
    localparam logic [31:0] OP_STORE  = 32'd11;
    localparam logic [31:0] OP_INPUT  = 32'd12;
    localparam logic [31:0] OP_OUTPUT = 32'd13;
    localparam logic [31:0] OP_STOP   = 32'd14;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_DIV0    = 3'd2;
    localparam logic [2:0] ST_BADOP   = 3'd3;
    localparam logic [2:0] ST_BADADDR = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  load_address;
        logic [31:0] load_word;
        logic [31:0] input_value;
    } req_t;

    typedef struct packed {
        logic [7:0]  prog_counter;
        logic [31:0] accum_value;
        logic        out_valid;
        logic [31:0] out_value;
        logic [2:0]  status;
    } rsp_t;
endpackage

@@ sv/ams_ram.sv @@
// Generic single-port-write RAM with one registered read port.
module ams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/ams_front.sv @@
// Front end: accepts items into a short queue for the execution engine.
module ams_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  ams_pkg::req_t  in_req,
    output logic           q_valid,
    output ams_pkg::req_t  q_req,
    input  logic           q_take
);
    import ams_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_req   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_take && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push && !full) - 2'(q_take && q_valid);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue count overflow");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("take from empty queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !q_take) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not advance");
`endif
endmodule

@@ sv/ams_div.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module ams_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] rem_reg, quo_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg, done_reg;
    logic [32:0] trial;
    logic [31:0] rem_sh;

    assign rem_sh   = {rem_reg[30:0], quo_reg[31]};
    assign trial    = {1'b0, rem_sh} - {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            quo_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            den_reg <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end
endmodule

@@ sv/ams_exec.sv @@
// Execution engine: fetch, operand read, arithmetic, writeback, result queue.
module ams_exec #(
    parameter int MEM_WORDS = ams_pkg::MEM_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ams_pkg::req_t q_req,
    output logic          q_take,
    output logic          empty,
    input  logic          pop,
    output ams_pkg::rsp_t rsp
);
    import ams_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OP    = 4'd1;
    localparam logic [3:0] S_A1    = 4'd2;
    localparam logic [3:0] S_A2    = 4'd3;
    localparam logic [3:0] S_DAT   = 4'd4;
    localparam logic [3:0] S_EXE   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    logic [3:0]    state_reg;
    logic [AW-1:0] pc_reg;
    logic [31:0]   acc_reg;
    logic          halted_reg;
    logic [31:0]   op_reg, a1_reg, a2_reg, x_reg, ival_reg, mul_reg;
    rsp_t          rsp_reg;
    logic          rsp_full_reg;

    logic          code_we, data_we;
    logic [AW-1:0] code_waddr, data_waddr, code_raddr, data_raddr;
    logic [31:0]   code_wdata, data_wdata, code_rdata, data_rdata;
    logic          div_start, div_done;
    logic [31:0]   div_q;

    ams_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_code (
        .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
        .raddr(code_raddr), .rdata(code_rdata));
    ams_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_data (
        .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
        .raddr(data_raddr), .rdata(data_rdata));
    ams_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_reg),
        .divisor(x_reg), .done(div_done), .quotient(div_q));

    function automatic logic in_rng(input logic [32:0] a);
        return a < 33'(MEM_WORDS);
    endfunction

    logic [32:0] pc1, pc2, npc_seq;
    logic        is_copy, is_jmp, take, load_ok;
    logic [31:0] npc_jmp;

    assign pc1     = 33'(pc_reg) + 33'd1;
    assign pc2     = 33'(pc_reg) + 33'd2;
    assign is_copy = (op_reg == OP_COPY);
    assign is_jmp  = (op_reg >= OP_JMP) && (op_reg <= OP_JMPZ);
    assign npc_seq = is_copy ? 33'(pc_reg) + 33'd3 : pc2;
    assign load_ok = in_rng(33'(q_req.load_address));

    always_comb
    begin
        case (op_reg)
            OP_JMP:  take = 1'b1;
            OP_JMPN: take = acc_reg[31];
            OP_JMPP: take = !acc_reg[31] && (acc_reg != 32'd0);
            OP_JMPZ: take = (acc_reg == 32'd0);
            default: take = 1'b0;
        endcase
        npc_jmp = take ? a1_reg : npc_seq[31:0];
    end

    assign empty  = !rsp_full_reg;
    assign rsp    = rsp_reg;
    assign q_take = (state_reg == S_DONE);

    logic [3:0]    state_next;
    logic [AW-1:0] pc_next;
    logic [31:0]   acc_next;
    logic          halted_next, finish;
    rsp_t          res;

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        finish      = 1'b0;
        res         = '0;
        code_we     = 1'b0;
        data_we     = 1'b0;
        code_waddr  = AW'(q_req.load_address);
        code_wdata  = q_req.load_word;
        data_waddr  = AW'(q_req.load_address);
        data_wdata  = q_req.load_word;
        code_raddr  = pc_reg;
        data_raddr  = a1_reg[AW-1:0];
        div_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (!q_req.req_type)
                    begin
                        code_we = load_ok;
                        data_we = load_ok;
                        finish  = 1'b1;
                        res.status = load_ok ? ST_OK : ST_BADADDR;
                    end
                    else if (halted_reg)
                    begin
                        finish = 1'b1;
                        res.status = ST_HALT;
                    end
                    else
                    begin
                        state_next = S_OP;
                    end
                end
            end
            S_OP:
            begin
                code_raddr = pc1[AW-1:0];
                state_next = S_A1;
            end
            S_A1:
            begin
                code_raddr = pc2[AW-1:0];
                if (op_reg < OP_ADD || op_reg > OP_STOP)
                begin
                    finish = 1'b1;
                    res.status = ST_BADOP;
                end
                else if (op_reg == OP_STOP)
                begin
                    pc_next     = in_rng(pc1) ? pc1[AW-1:0] : '0;
                    halted_next = 1'b1;
                    finish      = 1'b1;
                    res.status  = ST_HALT;
                end
                else if (!in_rng(pc1))
                begin
                    finish = 1'b1;
                    res.status = ST_BADADDR;
                end
                else
                begin
                    state_next = S_A2;
                end
            end
            S_A2:
            begin
                // second operand word is still on the read port here
                if (is_copy && !in_rng(pc2))
                begin
                    finish = 1'b1;
                    res.status = ST_BADADDR;
                end
                else if (is_jmp)
                begin
                    if (!in_rng({1'b0, npc_jmp}))
                    begin
                        res.status = ST_BADADDR;
                    end
                    else
                    begin
                        pc_next = npc_jmp[AW-1:0];
                    end
                    finish = 1'b1;
                end
                else if (!in_rng({1'b0, a1_reg}) ||
                         (is_copy && !in_rng({1'b0, code_rdata})))
                begin
                    finish = 1'b1;
                    res.status = ST_BADADDR;
                end
                else
                begin
                    state_next = S_DAT;
                end
            end
            S_DAT:
            begin
                state_next = S_EXE;
            end
            S_EXE:
            begin
                if (op_reg == OP_DIV && x_reg == 32'd0)
                begin
                    finish = 1'b1;
                    res.status = ST_DIV0;
                end
                else if (!in_rng(npc_seq))
                begin
                    finish = 1'b1;
                    res.status = ST_BADADDR;
                end
                else if (op_reg == OP_MUL)
                begin
                    state_next = S_MUL;
                end
                else if (op_reg == OP_DIV)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    finish  = 1'b1;
                    pc_next = npc_seq[AW-1:0];
                    case (op_reg)
                        OP_ADD:   acc_next = acc_reg + x_reg;
                        OP_SUB:   acc_next = acc_reg - x_reg;
                        OP_LOAD:  acc_next = x_reg;
                        OP_COPY:
                        begin
                            data_we    = 1'b1;
                            data_waddr = a2_reg[AW-1:0];
                            data_wdata = x_reg;
                        end
                        OP_STORE:
                        begin
                            data_we    = 1'b1;
                            data_waddr = a1_reg[AW-1:0];
                            data_wdata = acc_reg;
                        end
                        OP_INPUT:
                        begin
                            data_we    = 1'b1;
                            data_waddr = a1_reg[AW-1:0];
                            data_wdata = ival_reg;
                        end
                        OP_OUTPUT:
                        begin
                            res.out_valid = 1'b1;
                            res.out_value = x_reg;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                finish   = 1'b1;
                acc_next = mul_reg;
                pc_next  = npc_seq[AW-1:0];
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    finish   = 1'b1;
                    acc_next = div_q;
                    pc_next  = npc_seq[AW-1:0];
                end
            end
            S_DONE:
            begin
                // retire the queued item; its result is already registered
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (finish)
        begin
            state_next = rsp_full_reg ? S_WAIT : S_DONE;
        end
        res.prog_counter = 8'(pc_next);
        res.accum_value  = acc_next;
    end

    rsp_t pend_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:  ival_reg <= q_req.input_value;
            S_OP:    op_reg   <= code_rdata;
            S_A1:    a1_reg   <= code_rdata;
            S_A2:    a2_reg   <= code_rdata;
            S_DAT:   x_reg    <= data_rdata;
            default: ;
        endcase
        if (state_reg == S_EXE)
        begin
            mul_reg <= acc_reg * x_reg;
        end
        if (finish)
        begin
            pend_reg <= res;
        end
        if (finish && !rsp_full_reg)
        begin
            rsp_reg <= res;
        end
        else if (state_reg == S_WAIT && !rsp_full_reg)
        begin
            rsp_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            acc_reg      <= 32'd0;
            halted_reg   <= 1'b0;
            rsp_full_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
            if (state_reg == S_WAIT)
            begin
                state_reg <= rsp_full_reg ? S_WAIT : S_DONE;
            end
            else
            begin
                state_reg <= state_next;
            end
            if ((finish && !rsp_full_reg) || (state_reg == S_WAIT && !rsp_full_reg))
            begin
                rsp_full_reg <= 1'b1;
            end
            else if (pop && rsp_full_reg)
            begin
                rsp_full_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("item retired with no queued item");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> rsp_full_reg) else $error("item retired without a result");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg) else $error("halt flag cleared");
`endif
endmodule

@@ sv/accumulator_machine_step_unit.sv @@
// Accumulator machine: load items write the program image and step items run one
// instruction each. Loads and steps while halted end in idle, stop and a bad opcode once
// the opcode is read, a jump after its target; other opcodes read the opcode and two
// operand words from the code store, then one data-store read, all through registered
// RAM ports; div also waits on the 32-step bit-serial divider. An error ends the item at
// the cycle that detects it. Two items queue at the input; one finished result waits at
// the output and one more is held inside, after which the engine stalls until pop.
module accumulator_machine_step_unit #(
    parameter int MEM_WORDS = ams_pkg::MEM_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [7:0]  load_address,
    input  logic [31:0] load_word,
    input  logic [31:0] input_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  prog_counter,
    output logic [31:0] accum_value,
    output logic        out_valid,
    output logic [31:0] out_value,
    output logic [2:0]  status
);
    import ams_pkg::*;

    req_t in_req, q_req;
    rsp_t rsp;
    logic q_valid, q_take;

    assign in_req = '{req_type: req_type, load_address: load_address,
                      load_word: load_word, input_value: input_value};

    ams_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_req(in_req),
        .q_valid(q_valid), .q_req(q_req), .q_take(q_take));

    ams_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .q_take(q_take), .empty(empty), .pop(pop), .rsp(rsp));

    assign prog_counter = rsp.prog_counter;
    assign accum_value  = rsp.accum_value;
    assign out_valid    = rsp.out_valid;
    assign out_value    = rsp.out_value;
    assign status       = rsp.status;
endmodule

@@ sim/accumulator_machine_step_unit_tb.sv @@
// Testbench: directed and random programs for the accumulator machine, checked by a predictor.
`timescale 1ns / 100ps

module accumulator_machine_step_unit_tb;
    import ams_pkg::*;

    localparam int WORDS      = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        req_type;
    logic [7:0]  load_address;
    logic [31:0] load_word;
    logic [31:0] input_value;
    logic        empty;
    logic        pop;
    logic [7:0]  prog_counter;
    logic [31:0] accum_value;
    logic        out_valid;
    logic [31:0] out_value;
    logic [2:0]  status;

    // machine state as predicted
    logic [31:0] code_mem [WORDS];
    logic [31:0] data_mem [WORDS];
    logic [31:0] pc_q;
    logic [31:0] acc_q;
    logic        halt_q;

    rsp_t        expected_rsp_q [$];
    int          errors;
    int          idle_pct;
    int          stall_pct;
    int          stall_cycles;
    int          load_cnt;
    int          step_cnt;
    int          output_cnt;
    int          fault_cnt;

    accumulator_machine_step_unit uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .load_address(load_address), .load_word(load_word),
        .input_value(input_value), .empty(empty), .pop(pop),
        .prog_counter(prog_counter), .accum_value(accum_value),
        .out_valid(out_valid), .out_value(out_value), .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit fits(input logic [31:0] a);
        return a < WORDS;
    endfunction

    function automatic logic [31:0] div_toward_zero(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        if (a[31] != b[31])
            q = -q;
        return q;
    endfunction

    function automatic rsp_t machine_predict(input req_t r);
        rsp_t        o;
        logic [31:0] op;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] x;
        logic [31:0] npc;
        logic [31:0] nacc;
        int          nops;
        bit          take;
        o.out_valid = 1'b0;
        o.out_value = '0;
        o.status    = ST_OK;
        a2 = '0;
        if (!r.req_type)
        begin
            code_mem[r.load_address] = r.load_word;
            data_mem[r.load_address] = r.load_word;
        end
        else if (halt_q)
            o.status = ST_HALT;
        else
        begin
            op = code_mem[pc_q[7:0]];
            nops = (op == OP_COPY) ? 2 : 1;
            if (op < OP_ADD || op > OP_STOP)
                o.status = ST_BADOP;
            else if (op == OP_STOP)
            begin
                npc = pc_q + 1;
                pc_q = fits(npc) ? npc : '0;
                halt_q = 1'b1;
                o.status = ST_HALT;
            end
            else if (!fits(pc_q + 1) || (nops == 2 && !fits(pc_q + 2)))
                o.status = ST_BADADDR;
            else
            begin
                a1 = code_mem[pc_q[7:0] + 8'd1];
                if (nops == 2)
                    a2 = code_mem[pc_q[7:0] + 8'd2];
                npc = pc_q + 1 + nops;
                nacc = acc_q;
                if (op >= OP_JMP && op <= OP_JMPZ)
                begin
                    case (op)
                        OP_JMP:  take = 1'b1;
                        OP_JMPN: take = acc_q[31];
                        OP_JMPP: take = acc_q != 0 && !acc_q[31];
                        default: take = acc_q == 0;
                    endcase
                    if (take)
                        npc = a1;
                    if (!fits(npc))
                        o.status = ST_BADADDR;
                    else
                        pc_q = npc;
                end
                else if (!fits(a1) || (nops == 2 && !fits(a2)))
                    o.status = ST_BADADDR;
                else
                begin
                    x = data_mem[a1[7:0]];
                    if (op == OP_DIV && x == 0)
                        o.status = ST_DIV0;
                    else if (!fits(npc))
                        o.status = ST_BADADDR;
                    else
                    begin
                        case (op)
                            OP_ADD:   nacc = acc_q + x;
                            OP_SUB:   nacc = acc_q - x;
                            OP_MUL:   nacc = acc_q * x;
                            OP_DIV:   nacc = div_toward_zero(acc_q, x);
                            OP_COPY:  data_mem[a2[7:0]] = x;
                            OP_LOAD:  nacc = x;
                            OP_STORE: data_mem[a1[7:0]] = acc_q;
                            OP_INPUT: data_mem[a1[7:0]] = r.input_value;
                            default:  ;
                        endcase
                        acc_q = nacc;
                        pc_q = npc;
                        if (op == OP_OUTPUT)
                        begin
                            o.out_valid = 1'b1;
                            o.out_value = x;
                        end
                    end
                end
            end
        end
        o.prog_counter = pc_q[7:0];
        o.accum_value  = acc_q;
        return o;
    endfunction

    // Leave push high after acceptance so back-to-back items need no extra edge.
    task automatic send_item(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        req_type     <= r.req_type;
        load_address <= r.load_address;
        load_word    <= r.load_word;
        input_value  <= r.input_value;
        do
            @(posedge clk);
        while (full);
        expected_rsp_q.insert(expected_rsp_q.size(), machine_predict(r));
        if (r.req_type)
            step_cnt++;
        else
            load_cnt++;
    endtask

    task automatic load_item(input logic [7:0] a, input logic [31:0] w);
        req_t r;
        r.req_type     = 1'b0;
        r.load_address = a;
        r.load_word    = w;
        r.input_value  = $urandom;
        send_item(r);
    endtask

    task automatic step_item(input logic [31:0] v);
        req_t r;
        r.req_type     = 1'b1;
        r.load_address = 8'($urandom);
        r.load_word    = $urandom;
        r.input_value  = v;
        send_item(r);
    endtask

    task automatic hold_until_drained();
        while (expected_rsp_q.size() != 0)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        rsp_t w;
        if (rst_n && pop && !empty)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                w = expected_rsp_q.pop_front();
                if (prog_counter !== w.prog_counter)
                    report_mismatch("prog_counter", prog_counter, w.prog_counter);
                if (accum_value !== w.accum_value)
                    report_mismatch("accum_value", accum_value, w.accum_value);
                if (out_valid !== w.out_valid)
                    report_mismatch("out_valid", out_valid, w.out_valid);
                if (out_value !== w.out_value)
                    report_mismatch("out_value", out_value, w.out_value);
                if (status !== w.status)
                    report_mismatch("status", status, w.status);
                if (w.out_valid)
                    output_cnt++;
                if (w.status > ST_HALT)
                    fault_cnt++;
            end
        end
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // Fill every word so no later step reads an unwritten entry; lay a program at 0.
    task automatic test_preload();
        logic [31:0] img [WORDS];
        for (int i = 0; i < WORDS; i++)
            img[i] = $urandom;
        img[200] = 32'h8000_0000;
        img[201] = 32'hFFFF_FFFF;
        img[202] = 32'd0;
        img[203] = 32'd7;
        img[0]  = OP_LOAD;   img[1]  = 32'd200;
        img[2]  = OP_DIV;    img[3]  = 32'd201;
        img[4]  = OP_DIV;    img[5]  = 32'd202;
        img[6]  = OP_MUL;    img[7]  = 32'd201;
        img[8]  = OP_SUB;    img[9]  = 32'd203;
        img[10] = OP_ADD;    img[11] = 32'd200;
        img[12] = OP_INPUT;  img[13] = 32'd204;
        img[14] = OP_OUTPUT; img[15] = 32'd204;
        img[16] = OP_COPY;   img[17] = 32'd204; img[18] = 32'd205;
        img[19] = OP_STORE;  img[20] = 32'd206;
        img[21] = OP_JMPN;   img[22] = 32'd23;
        img[23] = OP_JMPZ;   img[24] = 32'd25;
        img[25] = OP_JMPP;   img[26] = 32'd27;
        img[27] = OP_JMP;    img[28] = 32'd29;
        img[29] = 32'd0;
        for (int i = 0; i < WORDS; i++)
            load_item(i[7:0], img[i]);
    endtask

    task automatic test_directed_ops();
        step_item($urandom);        // load the most negative word
        step_item($urandom);        // divide overflow wraps
        step_item($urandom);        // divide by zero, nothing moves
        load_item(8'd5, 32'd203);
        for (int i = 0; i < 5; i++)
            step_item(32'hFFFF_FFFF);
        step_item(32'h7FFF_FFFF);   // output
        step_item($urandom);        // copy
        step_item($urandom);        // store
        for (int i = 0; i < 4; i++)
            step_item($urandom);    // all four jumps
        step_item($urandom);        // zero opcode
        load_item(8'd29, 32'd15);
        step_item($urandom);        // opcode just past stop
        load_item(8'd29, OP_JMP);
        load_item(8'd30, 32'd300);
        step_item($urandom);        // jump target out of range
        load_item(8'd30, 32'd31);
        load_item(8'd31, OP_LOAD);
        load_item(8'd32, 32'h8000_0100);
        step_item($urandom);        // jump taken to 31
        step_item($urandom);        // data address out of range
        hold_until_drained();
    endtask

    function automatic logic [31:0] pick_opcode();
        logic [31:0] ops [13] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JMP, OP_JMPN, OP_JMPP,
                                  OP_JMPZ, OP_COPY, OP_LOAD, OP_STORE, OP_INPUT, OP_OUTPUT};
        return ops[$urandom_range(12)];
    endfunction

    function automatic logic [31:0] pick_operand();
        if ($urandom_range(9) == 0)
            return $urandom;
        return $urandom_range(WORDS - 1);
    endfunction

    task automatic test_random_programs(input int count);
        int          sent;
        logic [31:0] op;
        sent = 0;
        while (sent < count)
        begin
            case ((sent * 4) / count)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 77;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 77;
                end
                default:
                begin
                    idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            if ($urandom_range(9) < 7)
            begin
                // plant a valid instruction at the predicted pc, then run it
                op = pick_opcode();
                load_item(pc_q[7:0], op);
                load_item(pc_q[7:0] + 8'd1, pick_operand());
                sent += 2;
                if (op == OP_COPY)
                begin
                    load_item(pc_q[7:0] + 8'd2, pick_operand());
                    sent++;
                end
                repeat ($urandom_range(1, 3))
                begin
                    step_item($urandom);
                    sent++;
                end
            end
            else if ($urandom_range(1))
            begin
                load_item(8'($urandom), $urandom);
                sent++;
            end
            else
            begin
                step_item($urandom);
                sent++;
            end
            if (sent % 250 < 3)
                hold_until_drained();
        end
        idle_pct = 0;
        stall_pct = 0;
        hold_until_drained();
    endtask

    task automatic test_halt();
        load_item(8'd40, OP_JMP);
        load_item(8'd41, 32'd255);
        load_item(pc_q[7:0], OP_JMP);
        load_item(pc_q[7:0] + 8'd1, 32'd40);
        step_item($urandom);
        step_item($urandom);        // now at the last word
        load_item(8'd255, OP_ADD);
        step_item($urandom);        // operand position off the end
        load_item(8'd255, OP_STOP);
        step_item($urandom);        // stop wraps pc to zero
        step_item($urandom);        // halted
        load_item(8'd7, 32'hA5A5_5A5A);
        step_item($urandom);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        req_type = 1'b0;
        load_address = '0;
        load_word = '0;
        input_value = '0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        stall_cycles = 0;
        load_cnt = 0;
        step_cnt = 0;
        output_cnt = 0;
        fault_cnt = 0;
        pc_q = '0;
        acc_q = '0;
        halt_q = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_preload();
        test_directed_ops();
        test_random_programs(700);
        idle_pct = 35;
        stall_pct = 35;
        test_halt();

        push <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d load items and %0d step items over four idle/stall mixes",
                 load_cnt, step_cnt);
        $display("saw %0d output values and %0d fault results, ending halted", output_cnt,
                 fault_cnt);
        if (errors == 0 && expected_rsp_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
